/* hw/rtl/escaped_frame_deframer_core_defines.svh */
// Assertion macros for the escaped frame deframer.
`ifndef ESCAPED_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define ESCAPED_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define EFD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("efd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define EFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("efd: next-cycle check failed");

`endif

/* hw/rtl/efd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package efd_pkg;

	localparam int unsigned CodeW = 8;
	localparam int unsigned ApbAddrW = 3;
	localparam int unsigned ApbDataW = 32;

	localparam logic [CodeW-1:0] EscapeReset = 8'h48;
	localparam logic [CodeW-1:0] StartReset = 8'h10;

	typedef enum logic {
		REG_ESCAPE = 1'b0,
		REG_START = 1'b1
	} efd_reg_t;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_HUNT_ESC,
		ST_FRAME,
		ST_FRAME_ESC,
		ST_READ,
		ST_LOAD
	} efd_state_t;

	typedef struct packed {
		logic store;
		logic clear;
		logic rd_start;
		logic rd_issue;
		logic out_load;
	} efd_cmd_t;

	typedef struct packed {
		logic is_esc;
		logic is_start;
		logic len_zero;
		logic rd_last;
		logic out_free;
	} efd_status_t;

endpackage
`default_nettype wire

/* hw/rtl/efd_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
module efd_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [efd_pkg::ApbAddrW-1:0]   paddr,
	input  wire logic [efd_pkg::ApbDataW-1:0]   pwdata,
	output logic      [efd_pkg::ApbDataW-1:0]   prdata,
	output logic                                pready,
	output logic      [efd_pkg::CodeW-1:0]      escape_code,
	output logic      [efd_pkg::CodeW-1:0]      start_code
);
	import efd_pkg::*;

	logic [CodeW-1:0] escape_q;
	logic [CodeW-1:0] start_q;
	logic             wr_en;
	efd_reg_t         reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_sel = efd_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= EscapeReset;
			start_q <= StartReset;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_ESCAPE: escape_q <= pwdata[CodeW-1:0];
				REG_START:  start_q <= pwdata[CodeW-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ESCAPE: prdata = {{(ApbDataW-CodeW){1'b0}}, escape_q};
			REG_START:  prdata = {{(ApbDataW-CodeW){1'b0}}, start_q};
			default:    prdata = '0;
		endcase
	end

	assign escape_code = escape_q;
	assign start_code = start_q;

endmodule
`default_nettype wire

/* hw/rtl/efd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module efd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire efd_pkg::efd_status_t status,
	output efd_pkg::efd_cmd_t         cmd
);
	import efd_pkg::*;

	efd_state_t state_q;
	efd_state_t state_d;
	logic       fire;

	assign in_stall = (state_q == ST_READ) || (state_q == ST_LOAD);
	assign fire = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_HUNT: begin
				if (fire && status.is_esc) state_d = ST_HUNT_ESC;
			end
			ST_HUNT_ESC: begin
				if (fire) state_d = status.is_start ? ST_FRAME : ST_HUNT;
			end
			ST_FRAME: begin
				if (fire && status.is_esc) state_d = ST_FRAME_ESC;
			end
			ST_FRAME_ESC: begin
				if (fire) begin
					priority if (status.is_start) begin
						state_d = status.len_zero ? ST_HUNT : ST_READ;
					end else if (status.is_esc) begin
						state_d = ST_FRAME;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: begin
				if (status.out_free) state_d = status.rd_last ? ST_HUNT : ST_READ;
			end
			default: state_d = ST_HUNT;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_HUNT: ;
			ST_HUNT_ESC: begin
				cmd.clear = fire & status.is_start;
			end
			ST_FRAME: begin
				cmd.store = fire & ~status.is_esc;
			end
			ST_FRAME_ESC: begin
				if (fire) begin
					priority if (status.is_start) begin
						cmd.rd_start = 1'b1;
						cmd.clear = status.len_zero;
					end else if (status.is_esc) begin
						cmd.store = 1'b1;
					end else begin
						cmd.clear = 1'b1;
					end
				end
			end
			ST_READ: cmd.rd_issue = 1'b1;
			ST_LOAD: begin
				cmd.out_load = status.out_free;
				cmd.clear = status.out_free & status.rd_last;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/efd_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
module efd_dpath #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [efd_pkg::CodeW-1:0]   in_byte,
	input  wire logic [efd_pkg::CodeW-1:0]   escape_code,
	input  wire logic [efd_pkg::CodeW-1:0]   start_code,
	input  wire efd_pkg::efd_cmd_t           cmd,
	output efd_pkg::efd_status_t             status,
	output logic                             frame_valid,
	input  wire logic                        frame_stall,
	output logic      [efd_pkg::CodeW-1:0]   frame_byte,
	output logic                             frame_last,
	output logic                             truncated
);
	import efd_pkg::*;

	localparam int unsigned LenW = $clog2(MAX_FRAME + 1);
	localparam int unsigned AddrW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
	localparam logic [LenW-1:0] LenMax = LenW'(MAX_FRAME);

	logic [CodeW-1:0] mem_q [MAX_FRAME];
	logic [CodeW-1:0] rd_data_q;
	logic [LenW-1:0]  len_q;
	logic [LenW-1:0]  rd_idx_q;
	logic [LenW-1:0]  rd_next;
	logic             ovf_q;
	logic             full;
	logic             out_valid_q;
	logic [CodeW-1:0] out_byte_q;
	logic             out_last_q;
	logic             out_trunc_q;

	assign full = (len_q == LenMax);
	assign rd_next = rd_idx_q + 1'b1;

	assign status.is_esc = (in_byte == escape_code);
	assign status.is_start = (in_byte == start_code);
	assign status.len_zero = (len_q == '0);
	assign status.rd_last = (rd_next == len_q);
	assign status.out_free = ~out_valid_q | ~frame_stall;

	always_ff @(posedge clk) begin
		if (cmd.store && !full) begin
			mem_q[len_q[AddrW-1:0]] <= in_byte;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem_q[rd_idx_q[AddrW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			priority if (cmd.clear) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.store) begin
				if (full) ovf_q <= 1'b1;
				else len_q <= len_q + 1'b1;
			end
			priority if (cmd.rd_start) begin
				rd_idx_q <= '0;
			end else if (cmd.out_load) begin
				rd_idx_q <= rd_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!frame_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_byte_q <= rd_data_q;
			out_last_q <= status.rd_last;
			out_trunc_q <= ovf_q;
		end
	end

	assign frame_valid = out_valid_q;
	assign frame_byte = out_byte_q;
	assign frame_last = out_last_q;
	assign truncated = out_trunc_q;

endmodule
`default_nettype wire

/* hw/rtl/escaped_frame_deframer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Input bytes: one per cycle while parsing; in_stall is high only while a frame drains.
// Drain: each payload byte takes a buffer read, then an output register load that waits while the output is held.
// After the closing transaction, the first result goes through the buffer read, then the output register load.
// Output register lets the next frame's bytes be taken while the last result waits.
// Reset (arst_n low, async): hunting, length and overflow cleared, codes 0x48 / 0x10.
module escaped_frame_deframer_core #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [efd_pkg::ApbAddrW-1:0]   paddr,
	input  wire logic [efd_pkg::ApbDataW-1:0]   pwdata,
	output logic      [efd_pkg::ApbDataW-1:0]   prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [efd_pkg::CodeW-1:0]      in_byte,
	output logic                                frame_valid,
	input  wire logic                           frame_stall,
	output logic      [efd_pkg::CodeW-1:0]      frame_byte,
	output logic                                frame_last,
	output logic                                truncated
);
	import efd_pkg::*;

	logic [CodeW-1:0] escape_code;
	logic [CodeW-1:0] start_code;
	efd_cmd_t         cmd;
	efd_status_t      status;

	efd_cfg_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.escape_code (escape_code),
		.start_code  (start_code)
	);

	efd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	efd_dpath #(
		.MAX_FRAME (MAX_FRAME)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (in_byte),
		.escape_code (escape_code),
		.start_code  (start_code),
		.cmd         (cmd),
		.status      (status),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_byte  (frame_byte),
		.frame_last  (frame_last),
		.truncated   (truncated)
	);

endmodule
`default_nettype wire

/* hw/rtl/efd_port_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "escaped_frame_deframer_core_defines.svh"
module efd_port_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_stall,
	input wire logic                         frame_valid,
	input wire logic                         frame_stall,
	input wire logic [efd_pkg::CodeW-1:0]    frame_byte,
	input wire logic                         frame_last,
	input wire logic                         truncated
);
	// stalled transaction holds
	`EFD_ASSERT_NEXT(a_out_hold, frame_valid && frame_stall, frame_valid && $stable(frame_byte) && $stable(frame_last) && $stable(truncated))
	// input reopens only once the final byte of the frame is shown
	`EFD_ASSERT_NOW(a_drain_ends_last, $fell(in_stall), frame_valid && frame_last)
	// bytes still to come keep the input stalled
	`EFD_ASSERT_NOW(a_mid_frame_stall, frame_valid && !frame_last, in_stall)
endmodule

bind escaped_frame_deframer_core efd_port_checker u_port_checker (.*);
`default_nettype wire

/* verif/escaped_frame_deframer_core_tb.sv */
`timescale 1ns / 1ps
module escaped_frame_deframer_core_tb;
	import efd_pkg::*;

	localparam int FrameDepth = 64;
	localparam int WatchdogLimit = 2000;
	localparam int DrainGap = 12;
	localparam int EndGap = 20;
	localparam int LongHold = 400;

	typedef struct packed {
		logic [CodeW-1:0] data;
		logic last;
		logic trunc;
	} frame_beat_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CodeW-1:0] in_byte = '0;
	logic frame_valid;
	logic frame_stall = 1'b0;
	logic [CodeW-1:0] frame_byte;
	logic frame_last;
	logic truncated;

	escaped_frame_deframer_core #(
		.MAX_FRAME(FrameDepth)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_byte(frame_byte),
		.frame_last(frame_last),
		.truncated(truncated)
	);

	// byte stream waiting to be offered, and frame bytes still owed by the block
	logic [CodeW-1:0] send_q[$];
	frame_beat_t frame_exp_q[$];

	// deframer shadow state
	logic [CodeW-1:0] esc_m = EscapeReset;
	logic [CodeW-1:0] start_m = StartReset;
	efd_state_t p_mode = ST_HUNT;
	logic [CodeW-1:0] p_store[FrameDepth];
	int p_len = 0;
	logic p_ovf = 1'b0;

	int idle_max = 3;
	bit hold_req = 1'b0;
	int err_count = 0;
	int in_gap;
	int rx_wait;
	int hold_cnt;
	bit hold_done;
	int quiet;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
		err_count++;
	endtask

	task automatic keep_byte(input logic [CodeW-1:0] b);
		if (p_len < FrameDepth) begin
			p_store[p_len] = b;
			p_len++;
		end else begin
			p_ovf = 1'b1;
		end
	endtask

	task automatic deframe_byte(input logic [CodeW-1:0] b);
		frame_beat_t beat;
		case (p_mode)
			ST_HUNT: begin
				if (b == esc_m)
					p_mode = ST_HUNT_ESC;
			end
			ST_HUNT_ESC: begin
				if (b == start_m) begin
					p_len = 0;
					p_ovf = 1'b0;
					p_mode = ST_FRAME;
				end else begin
					p_mode = ST_HUNT;
				end
			end
			ST_FRAME: begin
				if (b == esc_m)
					p_mode = ST_FRAME_ESC;
				else
					keep_byte(b);
			end
			ST_FRAME_ESC: begin
				// start test takes priority over escape
				if (b == start_m) begin
					for (int k = 0; k < p_len; k++) begin
						beat.data = p_store[k];
						beat.last = (k == p_len - 1);
						beat.trunc = p_ovf;
						frame_exp_q.push_back(beat);
					end
					p_len = 0;
					p_ovf = 1'b0;
					p_mode = ST_HUNT;
				end else if (b == esc_m) begin
					keep_byte(b);
					p_mode = ST_FRAME;
				end else begin
					p_len = 0;
					p_ovf = 1'b0;
					p_mode = ST_HUNT;
				end
			end
			default: p_mode = ST_HUNT;
		endcase
	endtask

	function automatic logic [CodeW-1:0] payload_byte();
		case ($urandom_range(0, 7))
			0: return esc_m;
			1: return start_m;
			default: return CodeW'($urandom);
		endcase
	endfunction

	task automatic push_frame(input int n, input bit close);
		logic [CodeW-1:0] b;
		send_q.push_back(esc_m);
		send_q.push_back(start_m);
		for (int i = 0; i < n; i++) begin
			b = payload_byte();
			if (b == esc_m)
				send_q.push_back(esc_m);
			send_q.push_back(b);
		end
		send_q.push_back(esc_m);
		if (close) begin
			send_q.push_back(start_m);
		end else begin
			do b = CodeW'($urandom); while (b == start_m || b == esc_m);
			send_q.push_back(b);
		end
	endtask

	task automatic random_traffic(input int n);
		int base;
		base = send_q.size();
		while (send_q.size() - base < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: push_frame($urandom_range(0, 8), 1'b1);
				5: push_frame($urandom_range(0, 6), 1'b0);
				6: send_q.push_back(payload_byte());
				7: begin
					send_q.push_back(esc_m);
					send_q.push_back(payload_byte());
				end
				8: push_frame($urandom_range(9, 20), 1'b1);
				default: begin
					// stray close pair while hunting
					send_q.push_back(esc_m);
					send_q.push_back(esc_m);
					send_q.push_back(start_m);
				end
			endcase
		end
	endtask

	task automatic wait_idle();
		while (send_q.size() != 0 || in_valid || frame_exp_q.size() != 0)
			@(negedge clk);
		repeat (DrainGap) @(negedge clk);
	endtask

	task automatic cfg_write(input efd_reg_t r, input logic [CodeW-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ApbAddrW'({r, 2'b00});
		pwdata <= {(ApbDataW-CodeW)'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		if (r == REG_ESCAPE)
			esc_m = v;
		else
			start_m = v;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				deframe_byte(in_byte);
			if (!in_valid || !in_stall) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (send_q.size() != 0) begin
					in_valid <= 1'b1;
					in_byte <= send_q.pop_front();
					in_gap <= $urandom_range(0, idle_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : rx_side
		int w;
		frame_beat_t want;
		if (!arst_n) begin
			frame_stall <= 1'b0;
			rx_wait <= 0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else begin
			w = rx_wait;
			if (frame_valid && !frame_stall) begin
				if (frame_exp_q.size() == 0) begin
					report_mismatch("unexpected transaction", frame_byte, 0);
				end else begin
					want = frame_exp_q.pop_front();
					if (frame_byte !== want.data)
						report_mismatch("frame_byte", frame_byte, want.data);
					if (frame_last !== want.last)
						report_mismatch("frame_last", frame_last, want.last);
					if (truncated !== want.trunc)
						report_mismatch("truncated", truncated, want.trunc);
				end
				w = $urandom_range(0, idle_max);
			end
			if (hold_req && !hold_done) begin
				frame_stall <= 1'b1;
				hold_cnt <= LongHold;
				hold_done <= 1'b1;
				rx_wait <= w;
			end else if (hold_cnt != 0) begin
				frame_stall <= 1'b1;
				hold_cnt <= hold_cnt - 1;
				rx_wait <= w;
			end else if (w != 0) begin
				frame_stall <= 1'b1;
				rx_wait <= w - 1;
			end else begin
				frame_stall <= 1'b0;
				rx_wait <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else begin
			if ((in_valid && !in_stall) || (frame_valid && !frame_stall) || (psel && penable)) begin
				quiet <= 0;
			end else if (quiet >= WatchdogLimit) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		logic [CodeW-1:0] directed[$];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// noise extremes, hunt escape swallowing an escape, empty frame,
		// stuffed escape with raw start code, aborted frame
		directed = '{8'h00, 8'hFF, 8'h48, 8'h48, 8'h10, 8'h48, 8'h10, 8'h48, 8'h10,
			8'h48, 8'h10, 8'h00, 8'hFF, 8'h48, 8'h48, 8'h10, 8'h48, 8'h10,
			8'h48, 8'h10, 8'h55, 8'h48, 8'h22, 8'h10};
		foreach (directed[i])
			send_q.push_back(directed[i]);
		wait_idle();

		random_traffic(15);
		wait_idle();

		cfg_write(REG_ESCAPE, 8'h00);
		cfg_write(REG_START, 8'hFF);
		random_traffic(12);
		wait_idle();

		cfg_write(REG_ESCAPE, 8'hFF);
		cfg_write(REG_START, 8'h00);
		idle_max = 0;
		random_traffic(12);
		wait_idle();

		// escape and start share one code
		cfg_write(REG_ESCAPE, 8'h5A);
		cfg_write(REG_START, 8'h5A);
		idle_max = 3;
		random_traffic(8);
		wait_idle();

		cfg_write(REG_ESCAPE, CodeW'($urandom));
		cfg_write(REG_START, CodeW'($urandom));
		random_traffic(8);
		wait_idle();

		// long receiver hold-off with overflowing and exactly full frames
		cfg_write(REG_ESCAPE, EscapeReset);
		cfg_write(REG_START, StartReset);
		hold_req = 1'b1;
		push_frame(66, 1'b1);
		push_frame(FrameDepth, 1'b1);
		push_frame(3, 1'b1);
		random_traffic(5);
		wait_idle();

		repeat (EndGap) @(negedge clk);
		if (frame_exp_q.size() != 0)
			report_mismatch("transactions never seen", frame_exp_q.size(), 0);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* escaped_frame_deframer_core.f */
+incdir+hw/rtl
hw/rtl/efd_pkg.sv
hw/rtl/efd_cfg_regs.sv
hw/rtl/efd_ctrl.sv
hw/rtl/efd_dpath.sv
hw/rtl/escaped_frame_deframer_core.sv
hw/rtl/efd_port_checker.sv
verif/escaped_frame_deframer_core_tb.sv
